// File: hdl/rfmd_pkg.sv
package rfmd_pkg;

    localparam int unsigned TIME_W      = 11;
    localparam int unsigned DELAY_W     = 8;
    localparam int unsigned DCNT_W      = DELAY_W + 1;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 11;
    localparam int unsigned COUNT_LIMIT = 1500;

    localparam logic [TIME_W-1:0] MAX_TIME_RST = TIME_W'(1500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONFIRM_DELAY     = 3'd0,
        CFG_MAX_REQUEST_TIME  = 3'd1,
        CFG_INHIBIT_INVALID   = 3'd2,
        CFG_INHIBIT_RANGE     = 3'd3,
        CFG_INHIBIT_PLACEMENT = 3'd4
    } t_cfg_idx;

endpackage

// File: hdl/request_fault_monitor_debounce.sv
// Request fault monitor with turn-on debounce.
// Input channel (i_valid/o_ready) carries one control tick of request flags
// per transaction; output channel (o_valid/i_ready) returns exactly one
// result per tick: the raw invalid, out of range and placement faults, the
// coordinated inhibit, the request run time and the debounced diagnosis.
// Configuration (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) is always
// ready; unknown indexes are dropped, data is truncated to the register width.
// Write it only while no tick is in flight.
// From input acceptance a tick passes the input register, then the result
// register. Throughput: one tick per clock while the output is not stalled,
// set by the single pass of counter/compare logic between the two registers.
// A stalled output holds its result; the input register still takes one
// more tick, then o_ready drops until the result is taken.
// Synchronous active-low reset clears both pipeline valids, the run and
// debounce counters, and loads the configuration reset values
// (max_request_time = 1500, everything else 0).
module request_fault_monitor_debounce #(
    parameter int unsigned COUNT_LIMIT = rfmd_pkg::COUNT_LIMIT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_request_active,
    input  logic                            i_request_sent,
    input  logic                            i_target_gear_changed,
    input  logic                            i_speed_request_changed,
    input  logic                            i_range_diag_in,
    input  logic                            i_placement_inhibit_in,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_fault_invalid,
    output logic                            o_fault_range,
    output logic                            o_fault_placement,
    output logic                            o_inhibit_coord,
    output logic [rfmd_pkg::TIME_W-1:0]     o_request_time,
    output logic                            o_diag_confirmed,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rfmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rfmd_pkg::*;

    localparam logic [TIME_W-1:0] LIMIT = TIME_W'(COUNT_LIMIT);

    // configuration
    logic [DELAY_W-1:0] r_confirm_delay;
    logic [TIME_W-1:0]  r_max_request_time;
    logic               r_inhibit_invalid;
    logic               r_inhibit_range;
    logic               r_inhibit_placement;

    // input register
    logic r_in_valid;
    logic r_active, r_sent, r_gear_chg, r_speed_chg, r_range_in, r_place_in;

    // state
    logic              r_run_prev;
    logic [TIME_W-1:0] r_run_count;
    logic [DCNT_W-1:0] r_inv_cnt, r_rng_cnt, r_plc_cnt;

    logic              n_run_prev;
    logic [TIME_W-1:0] n_run_count;
    logic [DCNT_W-1:0] n_inv_cnt, n_rng_cnt, n_plc_cnt;

    // result register
    logic              r_out_valid;
    logic              r_f_inv, r_f_rng, r_f_plc, r_inh, r_diag;
    logic [TIME_W-1:0] r_req_time;

    logic              advance;
    logic              f_inv, f_rng, f_plc, inh, running;
    logic [TIME_W-1:0] req_time;
    logic [TIME_W:0]   run_inc;
    logic [DCNT_W-1:0] span;
    logic              c_inv, c_rng, c_plc;

    function automatic logic [DCNT_W-1:0] debounce_next(
        input logic [DCNT_W-1:0] cnt,
        input logic              fault,
        input logic [DCNT_W-1:0] sp
    );
        logic [DCNT_W-1:0] m;
        m = (cnt < sp) ? cnt : sp;
        return fault ? (m + DCNT_W'(1)) : '0;
    endfunction

    assign advance     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        f_inv   = r_active && !r_sent;
        running = r_active && !r_gear_chg && !r_speed_chg;
        run_inc = {1'b0, r_run_count} + (TIME_W+1)'(1);

        n_run_count = r_run_count;
        if (running) begin
            if (!r_run_prev) begin
                n_run_count = '0;
            end else if (run_inc < {1'b0, LIMIT}) begin
                n_run_count = run_inc[TIME_W-1:0];
            end else begin
                n_run_count = LIMIT;
            end
        end
        req_time   = running ? n_run_count : '0;
        n_run_prev = running;
        f_rng      = req_time > r_max_request_time;
        inh        = r_range_in || r_place_in;
        f_plc      = r_active && inh;

        span      = {1'b0, r_confirm_delay} + DCNT_W'(1);
        n_inv_cnt = debounce_next(r_inv_cnt, f_inv && !r_inhibit_invalid, span);
        n_rng_cnt = debounce_next(r_rng_cnt, f_rng && !r_inhibit_range, span);
        n_plc_cnt = debounce_next(r_plc_cnt, f_plc && !r_inhibit_placement, span);
        c_inv     = n_inv_cnt >= span;
        c_rng     = n_rng_cnt >= span;
        c_plc     = n_plc_cnt >= span;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm_delay     <= '0;
            r_max_request_time  <= MAX_TIME_RST;
            r_inhibit_invalid   <= 1'b0;
            r_inhibit_range     <= 1'b0;
            r_inhibit_placement <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CONFIRM_DELAY:     r_confirm_delay     <= i_cfg_data[DELAY_W-1:0];
                CFG_MAX_REQUEST_TIME:  r_max_request_time  <= i_cfg_data[TIME_W-1:0];
                CFG_INHIBIT_INVALID:   r_inhibit_invalid   <= i_cfg_data[0];
                CFG_INHIBIT_RANGE:     r_inhibit_range     <= i_cfg_data[0];
                CFG_INHIBIT_PLACEMENT: r_inhibit_placement <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_run_prev  <= 1'b0;
            r_run_count <= '0;
            r_inv_cnt   <= '0;
            r_rng_cnt   <= '0;
            r_plc_cnt   <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_run_prev  <= n_run_prev;
                r_run_count <= n_run_count;
                r_inv_cnt   <= n_inv_cnt;
                r_rng_cnt   <= n_rng_cnt;
                r_plc_cnt   <= n_plc_cnt;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_active    <= i_request_active;
            r_sent      <= i_request_sent;
            r_gear_chg  <= i_target_gear_changed;
            r_speed_chg <= i_speed_request_changed;
            r_range_in  <= i_range_diag_in;
            r_place_in  <= i_placement_inhibit_in;
        end
        if (advance) begin
            r_f_inv    <= f_inv;
            r_f_rng    <= f_rng;
            r_f_plc    <= f_plc;
            r_inh      <= inh;
            r_req_time <= req_time;
            r_diag     <= c_inv || c_rng || c_plc;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_fault_invalid   = r_f_inv;
    assign o_fault_range     = r_f_rng;
    assign o_fault_placement = r_f_plc;
    assign o_inhibit_coord   = r_inh;
    assign o_request_time    = r_req_time;
    assign o_diag_confirmed  = r_diag;

endmodule
